// ===== rtl/bkvt_pkg.sv =====
// bounded key/value table: shared constants, operation codes and item types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bkvt_pkg;

    localparam int CAPACITY   = 256;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int OP_W       = 3;
    localparam int POS_W      = 8;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_UPDATE    = 3'd1;
    localparam logic [OP_W-1:0] OP_UPSERT    = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE     = 3'd3;
    localparam logic [OP_W-1:0] OP_CONTAINS  = 3'd4;
    localparam logic [OP_W-1:0] OP_GET_KEY   = 3'd5;
    localparam logic [OP_W-1:0] OP_GET_POS   = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [KEY_BITS-1:0]   key_in;
        logic [VALUE_BITS-1:0] value_in;
        logic [POS_W-1:0]      position;
    } t_req;

    typedef struct packed {
        logic                  success;
        logic [KEY_BITS-1:0]   key_out;
        logic [VALUE_BITS-1:0] value_out;
        logic [CNT_W-1:0]      entry_count;
        logic                  is_empty;
    } t_rsp;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_cmd;

endpackage
`default_nettype wire

// ===== rtl/bkvt_ram.sv =====
// bounded key/value table: pair store, one write and one registered read per cycle
// depends on bkvt_pkg
`timescale 1ns / 1ps
`default_nettype none
module bkvt_ram (
    input  wire logic              i_clk,
    input  wire bkvt_pkg::t_ram_cmd i_cmd,
    output bkvt_pkg::t_entry       o_rdata
);
    import bkvt_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        r_rdata <= r_mem[i_cmd.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/bkvt_seq.sv =====
// bounded key/value table: sequencer for search, append, update, erase shift and reads
// depends on bkvt_pkg; drives bkvt_ram through a t_ram_cmd
`timescale 1ns / 1ps
`default_nettype none
module bkvt_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire bkvt_pkg::t_req              i_req,
    input  wire logic [bkvt_pkg::CNT_W-1:0]  i_limit,
    output logic                             o_valid,
    output bkvt_pkg::t_rsp                   o_rsp,
    output bkvt_pkg::t_ram_cmd               o_ram,
    input  wire bkvt_pkg::t_entry            i_rdata
);
    import bkvt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MISS   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_POS    = 3'd4;

    logic [2:0]        r_state, n_state;
    t_req              r_req, n_req;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_valid, n_valid;
    t_rsp              r_rsp, n_rsp;

    always_comb begin
        logic                  match;
        logic                  last;
        logic                  hit;
        logic                  miss;
        logic                  ok;
        logic [KEY_BITS-1:0]   kout;
        logic [VALUE_BITS-1:0] vout;

        n_state = r_state;
        n_req   = r_req;
        n_idx   = r_idx;
        n_count = r_count;
        n_valid = 1'b0;
        n_rsp   = r_rsp;
        o_ram   = '0;
        ok      = 1'b0;
        kout    = '0;
        vout    = '0;

        match = (i_rdata.key == r_req.key_in);
        last  = !(({1'b0, r_idx} + CNT_W'(1)) < r_count);
        hit   = (r_state == S_SEARCH) && match;
        miss  = (r_state == S_MISS) || ((r_state == S_SEARCH) && !match && last);

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_idx = '0;
                    case (i_req.operation)
                        OP_GET_POS: begin
                            if ({1'b0, i_req.position} < r_count) begin
                                o_ram.raddr = i_req.position;
                                n_state     = S_POS;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        OP_INSERT, OP_UPDATE, OP_UPSERT, OP_ERASE,
                        OP_CONTAINS, OP_GET_KEY: begin
                            o_ram.raddr = '0;
                            n_state     = (r_count == '0) ? S_MISS : S_SEARCH;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (!match && !last) begin
                    o_ram.raddr = r_idx + ADDR_W'(1);
                    n_idx       = r_idx + ADDR_W'(1);
                end
            end
            S_SHIFT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx;
                o_ram.wdata = i_rdata;
                if (({1'b0, r_idx} + CNT_W'(2)) < r_count) begin
                    o_ram.raddr = r_idx + ADDR_W'(2);
                    n_idx       = r_idx + ADDR_W'(1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                    ok      = 1'b1;
                    n_valid = 1'b1;
                end
            end
            S_POS: begin
                ok      = 1'b1;
                kout    = i_rdata.key;
                vout    = i_rdata.value;
                n_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (hit) begin
            case (r_req.operation)
                OP_UPDATE, OP_UPSERT: begin
                    o_ram.we          = 1'b1;
                    o_ram.waddr       = r_idx;
                    o_ram.wdata.key   = r_req.key_in;
                    o_ram.wdata.value = r_req.value_in;
                    ok                = 1'b1;
                    n_valid           = 1'b1;
                end
                OP_ERASE: begin
                    if (last) begin
                        n_count = r_count - CNT_W'(1);
                        ok      = 1'b1;
                        n_valid = 1'b1;
                    end else begin
                        o_ram.raddr = r_idx + ADDR_W'(1);
                        n_state     = S_SHIFT;
                    end
                end
                OP_CONTAINS: begin
                    ok      = 1'b1;
                    n_valid = 1'b1;
                end
                OP_GET_KEY: begin
                    ok      = 1'b1;
                    vout    = i_rdata.value;
                    n_valid = 1'b1;
                end
                default: begin
                    n_valid = 1'b1;
                end
            endcase
        end

        if (miss) begin
            n_valid = 1'b1;
            if (((r_req.operation == OP_INSERT) || (r_req.operation == OP_UPSERT))
                    && (r_count < i_limit)) begin
                o_ram.we          = 1'b1;
                o_ram.waddr       = r_count[ADDR_W-1:0];
                o_ram.wdata.key   = r_req.key_in;
                o_ram.wdata.value = r_req.value_in;
                n_count           = r_count + CNT_W'(1);
                ok                = 1'b1;
            end
        end

        if (n_valid) begin
            n_state           = S_IDLE;
            n_rsp.success     = ok;
            n_rsp.key_out     = kout;
            n_rsp.value_out   = vout;
            n_rsp.entry_count = n_count;
            n_rsp.is_empty    = (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_req <= n_req;
        r_idx <= n_idx;
        r_rsp <= n_rsp;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule
`default_nettype wire

// ===== rtl/bounded_key_value_table_unit.sv =====
// bounded key/value table top level: limit register, sequencer and pair store
// depends on bkvt_pkg, bkvt_seq, bkvt_ram
//
//  channel   signals                         direction  handshake
//  request   start, busy, i_req              in         taken when start & !busy
//  result    o_result_valid, o_rsp           out        one-cycle strobe
//  config    i_cfg_we, i_cfg_wdata           in         written when i_cfg_we
//
// one item is searched from position 0, one stored pair per cycle through the single
// read port of the pair store, until a match or the last stored pair
// erase shifts the later pairs down in place of the rest of the search
// get by position reads the pair at that position; unknown operations and positions past
// the count are answered from the idle state, without a read
// reset clears the pair count and sets the limit to 256; stored pairs are not cleared
// busy holds off new items while one is at work; results cannot be stalled
`timescale 1ns / 1ps
`default_nettype none
module bounded_key_value_table_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire bkvt_pkg::t_req              i_req,
    output logic                             o_result_valid,
    output bkvt_pkg::t_rsp                   o_rsp,
    input  wire logic                        i_cfg_we,
    input  wire logic [bkvt_pkg::CNT_W-1:0]  i_cfg_wdata
);
    import bkvt_pkg::*;

    logic [CNT_W-1:0] r_max_entries;
    logic [CNT_W-1:0] limit;
    t_ram_cmd         ram_cmd;
    t_entry           ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= CNT_W'(CAPACITY);
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_wdata;
        end
    end

    // limit above capacity saturates
    assign limit = (r_max_entries > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : r_max_entries;

    bkvt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_req   (i_req),
        .i_limit (limit),
        .o_valid (o_result_valid),
        .o_rsp   (o_rsp),
        .o_ram   (ram_cmd),
        .i_rdata (ram_rdata)
    );

    bkvt_ram u_ram (
        .i_clk   (i_clk),
        .i_cmd   (ram_cmd),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// ===== dv/tb_bounded_key_value_table_unit.sv =====
// testbench for bounded_key_value_table_unit: directed table, then random phases over
// several capacity limits, every result checked in order against a typed expectation or a behavioral predictor
// depends on bkvt_pkg and the bounded_key_value_table_unit rtl
`timescale 1ns / 1ps
module tb_bounded_key_value_table_unit;
    import bkvt_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef enum {MIX_CHURN, MIX_FILL, MIX_DRAIN} t_mix;

    typedef struct packed {
        t_req req;
        logic typed;
        t_rsp rsp;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_req                 i_req = '0;
    logic                 o_result_valid;
    t_rsp                 o_rsp;
    logic                 i_cfg_we = 1'b0;
    logic [CNT_W-1:0]     i_cfg_wdata = '0;

    logic [KEY_BITS-1:0]   table_keys [CAPACITY];
    logic [VALUE_BITS-1:0] table_values [CAPACITY];
    int                    pair_count = 0;
    int                    limit_setting = 256;

    t_rsp      pending_results [$];
    t_stim_row directed_rows [$];
    int        failure_count = 0;
    int        cycle_count = 0;

    bounded_key_value_table_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .o_result_valid (o_result_valid),
        .o_rsp          (o_rsp),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_failure(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
        $display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
        failure_count++;
    endtask

    function automatic t_rsp predict_result(input t_req r);
        t_rsp rsp;
        int   hit_at;
        int   cap;
        int   i;
        logic hit;
        logic add;
        rsp = '0;
        add = 1'b0;
        cap = (limit_setting > CAPACITY) ? CAPACITY : limit_setting;
        hit_at = pair_count;
        for (i = 0; i < pair_count; i++) begin
            if (hit_at == pair_count && table_keys[ADDR_W'(i)] == r.key_in) hit_at = i;
        end
        hit = (hit_at < pair_count);
        case (r.operation)
            OP_INSERT: add = !hit;
            OP_UPDATE: begin
                if (hit) begin
                    table_values[ADDR_W'(hit_at)] = r.value_in;
                    rsp.success = 1'b1;
                end
            end
            OP_UPSERT: begin
                if (hit) begin
                    table_values[ADDR_W'(hit_at)] = r.value_in;
                    rsp.success = 1'b1;
                end else begin
                    add = 1'b1;
                end
            end
            OP_ERASE: begin
                if (hit) begin
                    for (i = hit_at; i + 1 < pair_count; i++) begin
                        table_keys[ADDR_W'(i)] = table_keys[ADDR_W'(i + 1)];
                        table_values[ADDR_W'(i)] = table_values[ADDR_W'(i + 1)];
                    end
                    pair_count--;
                    rsp.success = 1'b1;
                end
            end
            OP_CONTAINS: rsp.success = hit;
            OP_GET_KEY: begin
                if (hit) begin
                    rsp.value_out = table_values[ADDR_W'(hit_at)];
                    rsp.success = 1'b1;
                end
            end
            OP_GET_POS: begin
                if (int'(r.position) < pair_count) begin
                    rsp.key_out = table_keys[r.position];
                    rsp.value_out = table_values[r.position];
                    rsp.success = 1'b1;
                end
            end
            default: ;
        endcase
        if (add && pair_count < cap) begin
            table_keys[ADDR_W'(pair_count)] = r.key_in;
            table_values[ADDR_W'(pair_count)] = r.value_in;
            pair_count++;
            rsp.success = 1'b1;
        end
        rsp.entry_count = pair_count[CNT_W-1:0];
        rsp.is_empty = (pair_count == 0);
        return rsp;
    endfunction

    function automatic t_req random_item(input t_mix mix);
        t_req r;
        int   pick;
        int   top;
        r.operation = OP_W'($urandom_range(0, 7));
        r.value_in = $urandom;
        pick = $urandom_range(0, 99);
        if (pair_count > 0 && pick < 50) begin
            r.key_in = table_keys[ADDR_W'($urandom_range(0, pair_count - 1))];
        end else if (pick < 80) begin
            r.key_in = $urandom_range(0, 15);
        end else begin
            r.key_in = $urandom;
        end
        top = (pair_count > 255) ? 255 : pair_count;
        if ($urandom_range(0, 9) < 7) begin
            r.position = POS_W'($urandom_range(0, top));
        end else begin
            r.position = POS_W'($urandom_range(0, 255));
        end
        if (mix == MIX_FILL && $urandom_range(0, 99) < 85) begin
            r.operation = $urandom_range(0, 1) ? OP_INSERT : OP_UPSERT;
            r.key_in = $urandom;
        end
        if (mix == MIX_DRAIN && pair_count > 0 && $urandom_range(0, 99) < 75) begin
            r.operation = OP_ERASE;
            r.key_in = table_keys[ADDR_W'($urandom_range(0, pair_count - 1))];
        end
        return r;
    endfunction

    task automatic send_item(input t_req r, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] limit_value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= limit_value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_setting = int'(limit_value);
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] limit_value, input int items,
                             input int idle_pct, input t_mix mix);
        t_req r;
        int   gap;
        write_limit(limit_value);
        repeat (items) begin
            if ($urandom_range(0, 49) == 0) wait_idle();
            gap = 0;
            while ($urandom_range(0, 99) < idle_pct) gap++;
            r = random_item(mix);
            send_item(r, gap);
            pending_results.push_back(predict_result(r));
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                report_failure("result with no item pending", o_rsp.value_out, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (o_rsp.success !== want.success)
                    report_failure("success", 32'(o_rsp.success), 32'(want.success));
                if (o_rsp.key_out !== want.key_out)
                    report_failure("key_out", o_rsp.key_out, want.key_out);
                if (o_rsp.value_out !== want.value_out)
                    report_failure("value_out", o_rsp.value_out, want.value_out);
                if (o_rsp.entry_count !== want.entry_count)
                    report_failure("entry_count", 32'(o_rsp.entry_count),
                                   32'(want.entry_count));
                if (o_rsp.is_empty !== want.is_empty)
                    report_failure("is_empty", 32'(o_rsp.is_empty), 32'(want.is_empty));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        t_rsp      prediction;
        // empty table after reset, limit at its reset value
        directed_rows.push_back({{OP_GET_POS, 32'h0, 32'h0, 8'd0}, 1'b1,
                                 {1'b0, 32'h0, 32'h0, 9'd0, 1'b1}});
        directed_rows.push_back({{OP_CONTAINS, 32'h0, 32'h0, 8'd0}, 1'b1,
                                 {1'b0, 32'h0, 32'h0, 9'd0, 1'b1}});
        directed_rows.push_back({{OP_ERASE, 32'hffff_ffff, 32'h0, 8'd0}, 1'b1,
                                 {1'b0, 32'h0, 32'h0, 9'd0, 1'b1}});
        directed_rows.push_back({{OP_UPDATE, 32'h5, 32'h1234, 8'd0}, 1'b1,
                                 {1'b0, 32'h0, 32'h0, 9'd0, 1'b1}});
        directed_rows.push_back({{OP_GET_KEY, 32'h5, 32'h0, 8'd0}, 1'b1,
                                 {1'b0, 32'h0, 32'h0, 9'd0, 1'b1}});
        directed_rows.push_back({{OP_UNDEFINED, 32'h0, 32'h0, 8'd0}, 1'b1,
                                 {1'b0, 32'h0, 32'h0, 9'd0, 1'b1}});
        // extremes of key and value
        directed_rows.push_back({{OP_INSERT, 32'h0, 32'hffff_ffff, 8'd0}, 1'b1,
                                 {1'b1, 32'h0, 32'h0, 9'd1, 1'b0}});
        directed_rows.push_back({{OP_INSERT, 32'hffff_ffff, 32'h0, 8'd0}, 1'b1,
                                 {1'b1, 32'h0, 32'h0, 9'd2, 1'b0}});
        directed_rows.push_back({{OP_INSERT, 32'h0, 32'h5555_5555, 8'd0}, 1'b1,
                                 {1'b0, 32'h0, 32'h0, 9'd2, 1'b0}});
        directed_rows.push_back({{OP_GET_POS, 32'h0, 32'h0, 8'd1}, 1'b1,
                                 {1'b1, 32'hffff_ffff, 32'h0, 9'd2, 1'b0}});
        directed_rows.push_back({{OP_GET_KEY, 32'h0, 32'h0, 8'd0}, 1'b1,
                                 {1'b1, 32'h0, 32'hffff_ffff, 9'd2, 1'b0}});
        directed_rows.push_back({{OP_UPDATE, 32'h0, 32'h1234_5678, 8'd0}, 1'b0, 75'h0});
        directed_rows.push_back({{OP_UPSERT, 32'hffff_ffff, 32'ha5a5_a5a5, 8'd0}, 1'b0, 75'h0});
        directed_rows.push_back({{OP_UPSERT, 32'h8000_0000, 32'h5a5a_5a5a, 8'd0}, 1'b0, 75'h0});
        directed_rows.push_back({{OP_CONTAINS, 32'h8000_0000, 32'h0, 8'd0}, 1'b0, 75'h0});
        // position out of range, then the last position in range
        directed_rows.push_back({{OP_GET_POS, 32'h0, 32'h0, 8'd255}, 1'b1,
                                 {1'b0, 32'h0, 32'h0, 9'd3, 1'b0}});
        directed_rows.push_back({{OP_GET_POS, 32'h0, 32'h0, 8'd2}, 1'b0, 75'h0});
        // erase of the first pair shifts the rest down; later erases empty the table
        directed_rows.push_back({{OP_ERASE, 32'h0, 32'h0, 8'd0}, 1'b0, 75'h0});
        directed_rows.push_back({{OP_GET_POS, 32'h0, 32'h0, 8'd0}, 1'b0, 75'h0});
        directed_rows.push_back({{OP_GET_POS, 32'h0, 32'h0, 8'd2}, 1'b1,
                                 {1'b0, 32'h0, 32'h0, 9'd2, 1'b0}});
        directed_rows.push_back({{OP_UNDEFINED, 32'hffff_ffff, 32'hffff_ffff, 8'd255}, 1'b1,
                                 {1'b0, 32'h0, 32'h0, 9'd2, 1'b0}});
        directed_rows.push_back({{OP_ERASE, 32'hffff_ffff, 32'h0, 8'd0}, 1'b0, 75'h0});
        directed_rows.push_back({{OP_ERASE, 32'h8000_0000, 32'h0, 8'd0}, 1'b0, 75'h0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            send_item(row.req, 0);
            prediction = predict_result(row.req);
            pending_results.push_back(row.typed ? row.rsp : prediction);
        end

        run_phase(9'd8,   200, 0,  MIX_CHURN);
        run_phase(9'd0,   30,  67, MIX_CHURN);
        run_phase(9'd511, 350, 0,  MIX_FILL);
        run_phase(9'd3,   250, 37, MIX_DRAIN);
        run_phase(9'd1,   100, 67, MIX_DRAIN);
        run_phase(9'd256, 100, 0,  MIX_CHURN);

        wait_idle();
        repeat (600) @(posedge i_clk);
        if (failure_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
